// ----- src/lsmt_pkg.sv -----
package lsmt_pkg;

	// Field widths of the channels
	localparam int LIMIT_W = 17;
	localparam int NUM_W   = 17;
	localparam int TOT_W   = 17;
	localparam int MU_W    = 2;
	localparam int MERT_W  = 12;

	// Run tag kept in every sieve entry; tag zero never matches a live run
	localparam int EPOCH_W = 6;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

	localparam logic signed [MU_W-1:0] MU_ONE  = 2'sb01;
	localparam logic signed [MU_W-1:0] MU_ZERO = 2'sb00;
	localparam logic signed [MU_W-1:0] MU_NEG  = 2'sb11;

	localparam logic signed [MERT_W-1:0] MERT_MAX = 12'sd1024;
	localparam logic signed [MERT_W-1:0] MERT_MIN = -12'sd1024;

	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 6'd1;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 6'd63;

	// One word of the sieve memory: composite mark (as run tag), mobius, totient
	typedef struct packed {
		logic [EPOCH_W-1:0]      tag;
		logic signed [MU_W-1:0]  mu;
		logic [TOT_W-1:0]        phi;
	} sieve_entry_t;

	typedef struct packed {
		logic done;
		logic zero;
	} mod_status_t;

endpackage

// ----- src/lsmt_in_if.sv -----
interface lsmt_in_if import lsmt_pkg::*; ();
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

// ----- src/lsmt_out_if.sv -----
interface lsmt_out_if import lsmt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [NUM_W-1:0]         number;
	logic                     is_prime;
	logic signed [MU_W-1:0]   mobius;
	logic [TOT_W-1:0]         totient;
	logic signed [MERT_W-1:0] mertens;
	logic                     last;
	logic                     past_end;

	modport source (output valid, output number, output is_prime, output mobius,
		output totient, output mertens, output last, output past_end, input ready);
	modport sink (input valid, input number, input is_prime, input mobius,
		input totient, input mertens, input last, input past_end, output ready);
endinterface

// ----- src/lsmt_cfg_if.sv -----
interface lsmt_cfg_if import lsmt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LIMIT_W-1:0] limit;

	modport source (output valid, output limit, input ready);
	modport sink (input valid, input limit, output ready);
endinterface

// ----- src/linear_sieve_mobius_totient_core.sv -----
// Linear sieve core: every accepted item yields one result describing the next integer of
// the run (1, 2, 3, ... up to the effective limit, which is the limit register clamped to
// [1, MAX_N]); each result carries the integer, its prime flag, Mobius value, Euler totient
// and the saturated running Mertens sum, and items past the limit report past_end. A restart
// item starts a fresh run at 1. An item past the limit goes from the fetch straight to the
// result load; any other item reads its sieve word, loads the result, then walks the stored
// primes, marking n*p for each, and stops after the first prime that divides n, when n*p
// passes the limit or when the store is exhausted. A new item is taken only once that walk
// is over. The item rate is set by the remainder unit (two bits per cycle) and the single
// write port of the sieve memory. The result is loaded once the output register is free and
// waits there while the marking walk runs. After reset a clearing pass over all MAX_N+1 words
// runs before the first item is taken; the same pass also runs inside every 63rd restart,
// when the run tag wraps. Configuration writes are taken in every cycle.
module linear_sieve_mobius_totient_core import lsmt_pkg::*; #(
	parameter int MAX_N       = 65536,
	parameter int PRIME_SLOTS = 8192
) (
	input  logic       clk,
	input  logic       arst_n,
	lsmt_in_if.sink    item,
	lsmt_out_if.source result,
	lsmt_cfg_if.sink   cfg
);

	// number width holds MAX_N+1 (the run counter can sit one past the limit)
	localparam int NW     = $clog2(MAX_N + 2);
	localparam int SAW    = $clog2(MAX_N + 1);
	localparam int SDEPTH = MAX_N + 1;
	localparam int PAW    = $clog2(PRIME_SLOTS);
	localparam int CW     = $clog2(PRIME_SLOTS + 1);
	localparam int LW     = (NW > LIMIT_W) ? NW : LIMIT_W;
	localparam int PRODW  = 2 * NW;
	localparam int TOTPW  = TOT_W + NW;
	localparam int EW     = $bits(sieve_entry_t);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_FETCH = 4'd2;
	localparam logic [3:0] S_LOOK  = 4'd3;
	localparam logic [3:0] S_EMIT  = 4'd4;
	localparam logic [3:0] S_PREAD = 4'd5;
	localparam logic [3:0] S_PMUL  = 4'd6;
	localparam logic [3:0] S_PCHK  = 4'd7;
	localparam logic [3:0] S_PDIV  = 4'd8;

	// control state
	logic [3:0]               state_q;
	logic [LIMIT_W-1:0]       limit_q;
	logic [EPOCH_W-1:0]       epoch_q;
	logic [SAW-1:0]           clr_addr_q;
	logic                     clr_item_q;
	logic [NW-1:0]            nxt_q;
	logic signed [MERT_W-1:0] mert_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            j_q;
	logic                     out_valid_q;

	// per-item payload
	logic [NW-1:0]            cur_q;
	logic                     prime_q;
	logic signed [MU_W-1:0]   mu_q;
	logic [TOT_W-1:0]         phi_q;
	logic                     last_q;
	logic                     past_q;
	logic [NW-1:0]            p_q;
	logic [PRODW-1:0]         prod_q;
	logic [TOT_W-1:0]         tot_q;

	// output register
	logic [NUM_W-1:0]         out_num_q;
	logic                     out_prime_q;
	logic signed [MU_W-1:0]   out_mu_q;
	logic [TOT_W-1:0]         out_tot_q;
	logic signed [MERT_W-1:0] out_mert_q;
	logic                     out_last_q;
	logic                     out_past_q;

	// effective limit, clamped to [1, MAX_N]
	logic [LW-1:0] lim_ext;
	logic [NW-1:0] lim;

	assign lim_ext = LW'(limit_q);

	always_comb begin
		if (lim_ext == '0) begin
			lim = NW'(1);
		end else if (lim_ext > LW'(MAX_N)) begin
			lim = NW'(MAX_N);
		end else begin
			lim = NW'(lim_ext);
		end
	end

	// sieve memory: one word per integer, indexed by the integer itself
	logic               s_we;
	logic [SAW-1:0]     s_waddr;
	sieve_entry_t       s_wdata;
	logic               s_re;
	logic [SAW-1:0]     s_raddr;
	logic [EW-1:0]      s_rdata;
	sieve_entry_t       s_ent;

	// prime store: primes in the order found
	logic               p_we;
	logic [PAW-1:0]     p_waddr;
	logic               p_re;
	logic [PAW-1:0]     p_raddr;
	logic [NW-1:0]      p_rdata;

	mod_status_t        mod_st;

	logic past_now;
	logic is_one;
	logic marked;
	logic look_prime;
	logic signed [MU_W-1:0]   look_mu;
	logic [TOT_W-1:0]         look_phi;
	logic signed [MERT_W:0]   mert_sum;
	logic signed [MERT_W-1:0] mert_next;
	logic out_free;
	logic out_load;
	logic walk_stop;
	logic [PRODW-1:0] prod_full;
	logic [TOTPW-1:0] tot_full;
	logic signed [MU_W-1:0]   mark_mu;
	logic [TOT_W-1:0]         mark_phi;

	assign past_now = (cur_q > lim);
	assign s_ent    = sieve_entry_t'(s_rdata);

	// A word counts as marked only if it carries the tag of the current run;
	// bumping the tag on restart is what clears all marks at once.
	assign is_one     = (cur_q == NW'(1));
	assign marked     = (s_ent.tag == epoch_q);
	assign look_prime = !is_one && !marked;

	always_comb begin
		if (is_one) begin
			look_mu  = MU_ONE;
			look_phi = TOT_W'(1);
		end else if (marked) begin
			look_mu  = s_ent.mu;
			look_phi = s_ent.phi;
		end else begin
			look_mu  = MU_NEG;
			look_phi = TOT_W'(cur_q - NW'(1));
		end
	end

	// saturating Mertens update
	always_comb begin
		mert_sum = (MERT_W + 1)'(mert_q) + (MERT_W + 1)'(look_mu);
		if (mert_sum > (MERT_W + 1)'(MERT_MAX)) begin
			mert_next = MERT_MAX;
		end else if (mert_sum < (MERT_W + 1)'(MERT_MIN)) begin
			mert_next = MERT_MIN;
		end else begin
			mert_next = MERT_W'(mert_sum);
		end
	end

	// n*p for the bound and the mark address; phi*p for the totient of the multiple
	assign prod_full = PRODW'(cur_q) * PRODW'(p_rdata);
	assign tot_full  = TOTPW'(phi_q) * TOTPW'(p_rdata);

	// p < 2 can only come from a corrupted store; treated as end of walk
	assign walk_stop = (p_q < NW'(2)) || (prod_q > PRODW'(lim));

	// divisible: mu 0, phi*p; otherwise -mu, phi*(p-1) = phi*p - phi
	assign mark_mu  = mod_st.zero ? MU_ZERO : MU_W'(-mu_q);
	assign mark_phi = mod_st.zero ? tot_q : (tot_q - phi_q);

	assign out_free = !out_valid_q || result.ready;
	assign out_load = (state_q == S_EMIT) && out_free;

	// Memory ports. Marks always land above the integer being read (n*p > n), and the
	// walk of an item ends before the next item reads its word, so no forwarding is needed.
	always_comb begin
		s_we    = 1'b0;
		s_waddr = clr_addr_q;
		s_wdata = '0;
		if (state_q == S_CLEAR) begin
			s_we = 1'b1;
		end else if ((state_q == S_PDIV) && mod_st.done) begin
			s_we        = 1'b1;
			s_waddr     = prod_q[SAW-1:0];
			s_wdata.tag = epoch_q;
			s_wdata.mu  = mark_mu;
			s_wdata.phi = mark_phi;
		end
	end

	assign s_re    = (state_q == S_FETCH) && !past_now;
	assign s_raddr = cur_q[SAW-1:0];

	// a prime found with the store full is reported but not kept
	assign p_we    = (state_q == S_LOOK) && look_prime && (count_q < CW'(PRIME_SLOTS));
	assign p_waddr = count_q[PAW-1:0];
	assign p_re    = (state_q == S_PREAD) && (j_q < count_q);
	assign p_raddr = j_q[PAW-1:0];

	lsmt_ram #(
		.WIDTH (EW),
		.DEPTH (SDEPTH)
	) u_sieve_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	lsmt_ram #(
		.WIDTH (NW),
		.DEPTH (PRIME_SLOTS)
	) u_prime_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (cur_q),
		.re    (p_re),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	// n mod p, started as soon as the prime arrives from the store
	lsmt_mod_unit #(
		.W (NW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_PMUL),
		.dividend (cur_q),
		.divisor  (p_rdata),
		.status   (mod_st)
	);

	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			limit_q     <= LIMIT_RESET;
			epoch_q     <= EPOCH_FIRST;
			clr_addr_q  <= '0;
			clr_item_q  <= 1'b0;
			nxt_q       <= NW'(1);
			mert_q      <= '0;
			count_q     <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.limit;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					// sweep every word back to tag zero, then restart tags at the first run
					if (clr_addr_q == SAW'(MAX_N)) begin
						clr_addr_q <= '0;
						epoch_q    <= EPOCH_FIRST;
						clr_item_q <= 1'b0;
						state_q    <= clr_item_q ? S_FETCH : S_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (item.valid) begin
						if (item.restart) begin
							mert_q  <= '0;
							count_q <= '0;
							if (epoch_q == EPOCH_LAST) begin
								clr_item_q <= 1'b1;
								state_q    <= S_CLEAR;
							end else begin
								epoch_q <= epoch_q + 1'b1;
								state_q <= S_FETCH;
							end
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					state_q <= past_now ? S_EMIT : S_LOOK;
				end
				S_LOOK: begin
					mert_q <= mert_next;
					nxt_q  <= cur_q + NW'(1);
					if (p_we) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (past_q) begin
							state_q <= S_IDLE;
						end else begin
							j_q     <= '0;
							state_q <= S_PREAD;
						end
					end
				end
				S_PREAD: begin
					state_q <= (j_q < count_q) ? S_PMUL : S_IDLE;
				end
				S_PMUL: begin
					state_q <= S_PCHK;
				end
				S_PCHK: begin
					state_q <= walk_stop ? S_IDLE : S_PDIV;
				end
				S_PDIV: begin
					// walk ends at the first stored prime that divides n
					if (mod_st.done) begin
						if (mod_st.zero) begin
							state_q <= S_IDLE;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_PREAD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload and result capture
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && item.valid) begin
			cur_q <= item.restart ? NW'(1) : nxt_q;
		end
		if (state_q == S_FETCH) begin
			prime_q <= 1'b0;
			mu_q    <= MU_ZERO;
			phi_q   <= '0;
			last_q  <= 1'b0;
			past_q  <= past_now;
		end
		if (state_q == S_LOOK) begin
			prime_q <= look_prime;
			mu_q    <= look_mu;
			phi_q   <= look_phi;
			last_q  <= (cur_q == lim);
		end
		if (state_q == S_PMUL) begin
			p_q    <= p_rdata;
			prod_q <= prod_full;
			tot_q  <= tot_full[TOT_W-1:0];
		end
		if (out_load) begin
			out_num_q   <= past_q ? '0 : NUM_W'(cur_q);
			out_prime_q <= prime_q;
			out_mu_q    <= mu_q;
			out_tot_q   <= phi_q;
			out_mert_q  <= mert_q;
			out_last_q  <= last_q;
			out_past_q  <= past_q;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.number   = out_num_q;
	assign result.is_prime = out_prime_q;
	assign result.mobius   = out_mu_q;
	assign result.totient  = out_tot_q;
	assign result.mertens  = out_mert_q;
	assign result.last     = out_last_q;
	assign result.past_end = out_past_q;

	// a mark never targets the word of the integer being processed or below it
	a_mark_above: assert property (@(posedge clk) disable iff (!arst_n)
		(s_we && (state_q == S_PDIV)) |-> (prod_q > PRODW'(cur_q)))
		else $error("sieve mark at or below the current integer");

	// an accepted transaction always takes the sequencer out of idle
	a_item_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> (state_q != S_IDLE))
		else $error("accepted transaction left the sequencer idle");

	// outside the clearing pass the run tag must not be the cleared value
	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |-> (epoch_q != '0))
		else $error("run tag zero outside the clearing pass");

	a_mertens_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mert_q <= MERT_MAX) && (mert_q >= MERT_MIN))
		else $error("running Mertens sum out of range");

endmodule

// ----- src/lsmt_ram.sv -----
module lsmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH)-1:0]       waddr,
	input  logic [WIDTH-1:0]               wdata,
	input  logic                           re,
	input  logic [$clog2(DEPTH)-1:0]       raddr,
	output logic [WIDTH-1:0]               rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/lsmt_mod_unit.sv -----
module lsmt_mod_unit import lsmt_pkg::*; #(
	parameter int W = 17
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output mod_status_t  status
);

	// restoring remainder, two dividend bits per cycle
	localparam int STEPS = (W + 1) / 2;
	localparam int DW    = 2 * STEPS;
	localparam int CNTW  = $clog2(STEPS + 1);

	logic [DW-1:0]   quo_q;
	logic [W-1:0]    rem_q;
	logic [W-1:0]    div_q;
	logic [CNTW-1:0] cnt_q;

	logic [W:0]   r1x, r1, r2x, r2;
	logic [W-1:0] r1n;

	always_comb begin
		r1x = {rem_q, quo_q[DW-1]};
		r1  = (r1x >= {1'b0, div_q}) ? (r1x - {1'b0, div_q}) : r1x;
		r1n = r1[W-1:0];
		r2x = {r1n, quo_q[DW-2]};
		r2  = (r2x >= {1'b0, div_q}) ? (r2x - {1'b0, div_q}) : r2x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNTW'(STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= DW'(dividend);
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DW-3:0], 2'b00};
			rem_q <= r2[W-1:0];
		end
	end

	assign status.done = (cnt_q == '0);
	assign status.zero = (rem_q == '0);

endmodule

// ----- sim/linear_sieve_mobius_totient_core_tb.sv -----
module linear_sieve_mobius_totient_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lsmt_pkg::*;

	localparam int SIEVE_MAX       = 65536;
	localparam int PRIME_CAP       = 8192;
	// Items in the random part of the run
	localparam int RANDOM_ITEMS    = 500;
	// Longest run of a phase; big limits would otherwise take tens of thousands of items
	localparam int PHASE_CAP       = 120;
	// After the last result the marking walk can still be busy, with at most a few dozen marks
	// for the integers this run reaches; the settle wait covers it.
	localparam int SETTLE_CYCLES   = 2000;
	// Cycles with no transaction on any channel before the run is declared hung. The
	// clearing pass after reset (and on every 63rd restart) sweeps all MAX_N+1 words.
	localparam int WATCHDOG_CYCLES = 300000;

	// One row of the sieve output, as the result channel carries it
	typedef struct packed {
		logic [NUM_W-1:0]         number;
		logic                     is_prime;
		logic signed [MU_W-1:0]   mobius;
		logic [TOT_W-1:0]         totient;
		logic signed [MERT_W-1:0] mertens;
		logic                     last;
		logic                     past_end;
	} sieve_row_t;

	// Scoreboard: keeps its own copy of the sieve, predicts the row for every item the
	// block takes and matches the rows the block hands out in order.
	class sieve_scoreboard;
		logic [LIMIT_W-1:0] limit_reg;
		int unsigned        next_n;
		int                 mertens_sum;
		int unsigned        n_primes;
		bit                 marked [0:SIEVE_MAX];
		int                 mu_of [0:SIEVE_MAX];
		int unsigned        phi_of [0:SIEVE_MAX];
		int unsigned        primes [0:PRIME_CAP-1];
		sieve_row_t         rows_due [$];
		int unsigned        errors;

		function new();
			limit_reg   = LIMIT_RESET;
			next_n      = 1;
			mertens_sum = 0;
			n_primes    = 0;
			errors      = 0;
			marked      = '{default: 1'b0};
			mu_of       = '{default: 0};
			phi_of      = '{default: 0};
			primes      = '{default: 0};
		endfunction

		function void set_limit(logic [LIMIT_W-1:0] value);
			limit_reg = value;
		endfunction

		// Sieve one integer and queue the row it should produce
		function void advance_sieve(bit restart);
			sieve_row_t  row;
			int unsigned lim, n, p, m, j, phi;
			int          mu;
			longint      prod;
			bit          prime;

			lim = limit_reg;
			if (lim < 1) lim = 1;
			if (lim > SIEVE_MAX) lim = SIEVE_MAX;

			if (restart) begin
				marked      = '{default: 1'b0};
				next_n      = 1;
				mertens_sum = 0;
				n_primes    = 0;
			end

			n   = next_n;
			row = '0;
			if (n > lim) begin
				// past the end: only the running sum shows, state is left alone
				row.mertens  = MERT_W'(mertens_sum);
				row.past_end = 1'b1;
				rows_due.push_back(row);
				return;
			end

			prime = 1'b0;
			if (n == 1) begin
				mu_of[1]  = 1;
				phi_of[1] = 1;
			end else if (!marked[n]) begin
				prime     = 1'b1;
				mu_of[n]  = -1;
				phi_of[n] = (n - 1) & 32'h1FFFF;
				if (n_primes < PRIME_CAP) begin
					primes[n_primes] = n;
					n_primes++;
				end
			end

			mu  = mu_of[n];
			phi = phi_of[n];

			// linear sieve walk: mark n*p for stored primes up to the smallest factor of n
			for (j = 0; j < n_primes; j++) begin
				p    = primes[j];
				prod = longint'(n) * longint'(p);
				if (p < 2 || prod > longint'(lim)) break;
				m         = n * p;
				marked[m] = 1'b1;
				if (n % p == 0) begin
					mu_of[m]  = 0;
					phi_of[m] = int'((longint'(phi) * p) & 64'h1FFFF);
					break;
				end
				mu_of[m]  = -mu;
				phi_of[m] = int'((longint'(phi) * (p - 1)) & 64'h1FFFF);
			end

			mertens_sum += mu;
			if (mertens_sum > 1024) mertens_sum = 1024;
			if (mertens_sum < -1024) mertens_sum = -1024;

			row.number   = NUM_W'(n);
			row.is_prime = prime;
			row.mobius   = MU_W'(mu);
			row.totient  = TOT_W'(phi);
			row.mertens  = MERT_W'(mertens_sum);
			row.last     = (n == lim);
			row.past_end = 1'b0;
			rows_due.push_back(row);
			next_n = n + 1;
		endfunction

		function void check_field(string field, logic signed [31:0] want,
				logic signed [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void match_row(sieve_row_t got);
			sieve_row_t want;

			if (rows_due.size() == 0) begin
				$error("result transaction with no row pending: number %0d", got.number);
				errors++;
				return;
			end
			want = rows_due.pop_front();
			check_field("number", want.number, got.number);
			check_field("is_prime", want.is_prime, got.is_prime);
			check_field("mobius", want.mobius, got.mobius);
			check_field("totient", want.totient, got.totient);
			check_field("mertens", want.mertens, got.mertens);
			check_field("last", want.last, got.last);
			check_field("past_end", want.past_end, got.past_end);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	// set for the tail of the run: no idling on either side from then on
	bit   calm;

	lsmt_in_if  item_ch ();
	lsmt_out_if result_ch ();
	lsmt_cfg_if cfg_ch ();

	sieve_scoreboard sb = new();

	linear_sieve_mobius_totient_core #(
		.MAX_N       (SIEVE_MAX),
		.PRIME_SLOTS (PRIME_CAP)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch.sink),
		.result (result_ch.source),
		.cfg    (cfg_ch.sink)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Monitor and watchdog. Everything is sampled right after the rising edge, before any
	// nonblocking update of that edge lands, so each signal holds its pre-edge value.
	int unsigned quiet_cycles;

	always @(posedge clk) begin
		sieve_row_t got;
		bit         moved;

		moved = 1'b0;
		if (cfg_ch.valid && cfg_ch.ready) begin
			sb.set_limit(cfg_ch.limit);
			moved = 1'b1;
		end
		if (item_ch.valid && item_ch.ready) begin
			sb.advance_sieve(item_ch.restart);
			moved = 1'b1;
		end
		if (result_ch.valid && result_ch.ready) begin
			got.number   = result_ch.number;
			got.is_prime = result_ch.is_prime;
			got.mobius   = result_ch.mobius;
			got.totient  = result_ch.totient;
			got.mertens  = result_ch.mertens;
			got.last     = result_ch.last;
			got.past_end = result_ch.past_end;
			sb.match_row(got);
			moved = 1'b1;
		end

		if (moved) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Result side: ready drops in random bursts until the calm tail of the run
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// One item transaction. Valid stays high from one item to the next unless an idle
	// burst is taken, so it is never lowered and raised in the same time step.
	task automatic send_item(input bit restart_bit);
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.restart <= restart_bit;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	// Stop sending, wait for every pending row, then let the marking walk finish
	task automatic drain_and_settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.rows_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		drain_and_settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.limit <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned        sent, count, eff, i;
		logic [LIMIT_W-1:0] lim_val;
		bit                 fresh;

		item_ch.valid   <= 1'b0;
		item_ch.restart <= 1'b0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.limit    <= '0;
		calm            = 1'b0;
		arst_n          <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: first run straight out of reset at the reset limit, no restart item.
		// Covers 1, small primes, squares and a cube.
		for (i = 0; i < 10; i++) send_item(1'b0);

		// Limit 0 behaves as 1: integer 1 is last, the next item is past the end
		write_limit('0);
		send_item(1'b1);
		send_item(1'b0);

		// Short run to its limit and one past it
		write_limit(LIMIT_W'(6));
		send_item(1'b1);
		for (i = 0; i < 6; i++) send_item(1'b0);

		// Raise the limit mid run without a restart: continues at 7 with the old marks
		write_limit(LIMIT_W'(10));
		for (i = 0; i < 5; i++) send_item(1'b0);

		// Random phases: a limit per phase, mostly small so runs finish and hit past_end.
		// Most phases start with a restart; the rest carry on under the new limit.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					case ($urandom_range(0, 2))
						0: lim_val = LIMIT_RESET;
						1: lim_val = '1;
						default: lim_val = LIMIT_W'($urandom_range(65537, 131071));
					endcase
				end
				1: lim_val = LIMIT_W'($urandom_range(0, 2));
				default: lim_val = LIMIT_W'($urandom_range(3, 60));
			endcase

			eff = lim_val;
			if (eff < 1) eff = 1;
			if (eff > SIEVE_MAX) eff = SIEVE_MAX;
			if (eff >= PHASE_CAP) begin
				count = $urandom_range(60, PHASE_CAP);
			end else begin
				count = eff + $urandom_range(0, 4);
			end

			write_limit(lim_val);
			fresh = ($urandom_range(0, 4) != 0);
			for (i = 0; i < count && sent < RANDOM_ITEMS; i++) begin
				// an occasional stray restart breaks a run in the middle
				send_item((i == 0 && fresh) || $urandom_range(0, 49) == 0);
				sent++;
				if (sent > RANDOM_ITEMS * 4 / 5) calm = 1'b1;
			end
		end

		drain_and_settle();
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
